/* rtl/dfp_pkg.sv */
// Shared types and constants for the delimited frame parser.
package dfp_pkg;

  localparam int unsigned MAX_PAYLOAD = 64;
  localparam int unsigned HW_CAP      = 64;
  localparam int unsigned FILL_LIMIT  = (MAX_PAYLOAD < HW_CAP) ? MAX_PAYLOAD : HW_CAP;
  localparam int unsigned STORE_DEPTH = (MAX_PAYLOAD > HW_CAP) ? MAX_PAYLOAD : HW_CAP;
  localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);
  localparam int unsigned CNT_W       = 6;

  localparam logic [7:0] CH_OPEN  = 8'h23;
  localparam logic [7:0] CH_SEP   = 8'h40;
  localparam logic [7:0] CH_CLOSE = 8'h24;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_TYPE,
    PH_SEP,
    PH_DATA
  } phase_t;

  typedef enum logic [1:0] {
    EM_IDLE,
    EM_READ,
    EM_HOLD
  } emit_state_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } store_wr_t;

  typedef struct packed {
    logic             go;
    logic [7:0]       ftype;
    logic [CNT_W-1:0] len;
  } frame_start_t;

endpackage

/* rtl/delimited_frame_parser_unit.sv */
// Top level of the delimited frame parser.
// Input channel: one received byte per item (in_byte, byte_valid/byte_ready).
// Frames look like '#', type, '@', payload..., '$'. Bytes outside a frame,
// frames missing '@' and frames reaching 64 payload bytes give no result.
// Output channel: one item per payload byte (result_valid/result_ready) with
// frame_type, payload_byte, byte_index, frame_length and last; an empty
// frame gives a single item with empty_frame and last set.
// Throughput: one input byte per cycle while a frame is being collected.
// After the closing '$' is taken, byte_ready stays low until the frame's
// last result is taken. Once '$' is accepted, the first result passes the
// payload store's registered read port and then the output register (only
// the output register for an empty frame); each further result, once the
// previous one is taken, passes the same read port and output register.
// A stalled receiver holds the current result in the output register and
// the read-out waits; input stays blocked meanwhile.
// Reset (rst, synchronous) returns the parser to idle and drops any
// partial frame or pending read-out. The payload store is not cleared.
module delimited_frame_parser_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  output logic       byte_ready,
  input  logic [7:0] in_byte,
  output logic       result_valid,
  input  logic       result_ready,
  output logic [7:0] frame_type,
  output logic [7:0] payload_byte,
  output logic [5:0] byte_index,
  output logic [5:0] frame_length,
  output logic       empty_frame,
  output logic       last
);

  dfp_pkg::store_wr_t        wr;
  dfp_pkg::frame_start_t     start;
  logic                      emit_idle;
  logic                      rd_en;
  logic [dfp_pkg::ADDR_W-1:0] rd_addr;
  logic [7:0]                rd_data;

  assign byte_ready = emit_idle;

  dfp_parse u_parse (
    .clk     (clk),
    .rst     (rst),
    .accept  (byte_valid && byte_ready),
    .in_byte (in_byte),
    .wr      (wr),
    .start   (start)
  );

  dfp_store u_store (
    .clk     (clk),
    .wr      (wr),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  dfp_emit u_emit (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .idle         (emit_idle),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr),
    .rd_data      (rd_data),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .frame_type   (frame_type),
    .payload_byte (payload_byte),
    .byte_index   (byte_index),
    .frame_length (frame_length),
    .empty_frame  (empty_frame),
    .last         (last)
  );

endmodule

/* rtl/dfp_store.sv */
// Payload store: one write port, one read port with registered data.
module dfp_store (
  input  logic                      clk,
  input  dfp_pkg::store_wr_t        wr,
  input  logic                      rd_en,
  input  logic [dfp_pkg::ADDR_W-1:0] rd_addr,
  output logic [7:0]                rd_data
);

  logic [7:0] mem [dfp_pkg::STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/dfp_parse.sv */
// Byte-level frame recognizer; writes payload into the store.
module dfp_parse (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  logic [7:0]            in_byte,
  output dfp_pkg::store_wr_t    wr,
  output dfp_pkg::frame_start_t start
);

  localparam logic [dfp_pkg::CNT_W-1:0] FILL_LAST = dfp_pkg::CNT_W'(dfp_pkg::FILL_LIMIT - 1);

  dfp_pkg::phase_t             phase, phase_next;
  logic [7:0]                  held_type, held_type_next;
  logic [dfp_pkg::CNT_W-1:0]   fill_count, fill_count_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= dfp_pkg::PH_IDLE;
      held_type  <= 8'd0;
      fill_count <= '0;
    end else begin
      phase      <= phase_next;
      held_type  <= held_type_next;
      fill_count <= fill_count_next;
    end
  end

  always_comb begin
    phase_next      = phase;
    held_type_next  = held_type;
    fill_count_next = fill_count;
    wr.we           = 1'b0;
    wr.addr         = dfp_pkg::ADDR_W'(fill_count);
    wr.data         = in_byte;
    start.go        = 1'b0;
    start.ftype     = held_type;
    start.len       = fill_count;
    if (accept) begin
      case (phase)
        dfp_pkg::PH_IDLE: begin
          if (in_byte == dfp_pkg::CH_OPEN) phase_next = dfp_pkg::PH_TYPE;
        end
        dfp_pkg::PH_TYPE: begin
          held_type_next = in_byte;
          phase_next     = dfp_pkg::PH_SEP;
        end
        dfp_pkg::PH_SEP: begin
          phase_next = (in_byte == dfp_pkg::CH_SEP) ? dfp_pkg::PH_DATA : dfp_pkg::PH_IDLE;
        end
        dfp_pkg::PH_DATA: begin
          if (in_byte == dfp_pkg::CH_CLOSE) begin
            start.go        = 1'b1;
            fill_count_next = '0;
            phase_next      = dfp_pkg::PH_IDLE;
          end else begin
            wr.we = 1'b1;
            // overlong frame: dropped without any result
            if (fill_count == FILL_LAST) begin
              fill_count_next = '0;
              phase_next      = dfp_pkg::PH_IDLE;
            end else begin
              fill_count_next = fill_count + 1'b1;
            end
          end
        end
        default: phase_next = dfp_pkg::PH_IDLE;
      endcase
    end
  end

endmodule

/* rtl/dfp_emit.sv */
// Frame read-out sequencer with output register.
module dfp_emit (
  input  logic                       clk,
  input  logic                       rst,
  input  dfp_pkg::frame_start_t      start,
  output logic                       idle,
  output logic                       rd_en,
  output logic [dfp_pkg::ADDR_W-1:0] rd_addr,
  input  logic [7:0]                 rd_data,
  output logic                       result_valid,
  input  logic                       result_ready,
  output logic [7:0]                 frame_type,
  output logic [7:0]                 payload_byte,
  output logic [5:0]                 byte_index,
  output logic [5:0]                 frame_length,
  output logic                       empty_frame,
  output logic                       last
);

  dfp_pkg::emit_state_t      state, state_next;
  logic [dfp_pkg::CNT_W-1:0] idx, idx_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dfp_pkg::EM_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

  // output payload register
  always_ff @(posedge clk) begin
    if (state == dfp_pkg::EM_IDLE && start.go) begin
      frame_type   <= start.ftype;
      frame_length <= start.len;
      payload_byte <= 8'd0;
      byte_index   <= '0;
      empty_frame  <= (start.len == '0);
      last         <= (start.len == '0);
    end else if (state == dfp_pkg::EM_READ) begin
      payload_byte <= rd_data;
      byte_index   <= idx;
      last         <= (idx == frame_length - 6'd1);
    end
  end

  always_comb begin
    state_next   = state;
    idx_next     = idx;
    rd_en        = 1'b0;
    rd_addr      = dfp_pkg::ADDR_W'(idx);
    idle         = 1'b0;
    result_valid = 1'b0;
    case (state)
      dfp_pkg::EM_IDLE: begin
        idle = 1'b1;
        if (start.go) begin
          idx_next = '0;
          if (start.len == '0) begin
            state_next = dfp_pkg::EM_HOLD;
          end else begin
            rd_en      = 1'b1;
            rd_addr    = '0;
            state_next = dfp_pkg::EM_READ;
          end
        end
      end
      dfp_pkg::EM_READ: begin
        state_next = dfp_pkg::EM_HOLD;
      end
      dfp_pkg::EM_HOLD: begin
        result_valid = 1'b1;
        if (result_ready) begin
          if (last) begin
            state_next = dfp_pkg::EM_IDLE;
          end else begin
            idx_next   = idx + 1'b1;
            rd_en      = 1'b1;
            rd_addr    = dfp_pkg::ADDR_W'(idx + 1'b1);
            state_next = dfp_pkg::EM_READ;
          end
        end
      end
      default: state_next = dfp_pkg::EM_IDLE;
    endcase
  end

endmodule

/* rtl/dfp_checker.sv */
// Port-level checks for the delimited frame parser, bound to the top level.
module dfp_checker (
  input logic       clk,
  input logic       rst,
  input logic       byte_ready,
  input logic       result_valid,
  input logic       result_ready,
  input logic [7:0] frame_type,
  input logic [7:0] payload_byte,
  input logic [5:0] byte_index,
  input logic [5:0] frame_length,
  input logic       empty_frame,
  input logic       last
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(payload_byte)
      && $stable(byte_index) && $stable(frame_type) && $stable(last))
    else $error("stalled result changed");

  // input is blocked while a frame is being read out
  a_block: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !byte_ready)
    else $error("input accepted during read-out");

  a_last_idx: assert property (@(posedge clk) disable iff (rst)
    result_valid && !empty_frame |-> (last == (byte_index == frame_length - 6'd1)))
    else $error("last flag does not match index");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    result_valid && empty_frame |-> last && frame_length == 6'd0 && payload_byte == 8'd0
      && byte_index == 6'd0)
    else $error("bad empty frame result");

endmodule

bind delimited_frame_parser_unit dfp_checker u_dfp_checker (
  .clk          (clk),
  .rst          (rst),
  .byte_ready   (byte_ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .frame_type   (frame_type),
  .payload_byte (payload_byte),
  .byte_index   (byte_index),
  .frame_length (frame_length),
  .empty_frame  (empty_frame),
  .last         (last)
);

/* tb/tb_top.sv */
// Self-checking testbench for delimited_frame_parser_unit against a frame predictor.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned BYTE_TARGET = 380;

  typedef struct {
    logic [7:0] ftype;
    logic [7:0] pbyte;
    logic [5:0] idx;
    logic [5:0] len;
    logic       empty;
    logic       fin;
  } frame_result_t;

  class frame_scoreboard;
    dfp_pkg::phase_t phase;
    logic [7:0]      held_type;
    int unsigned     fill_count;
    logic [7:0]      payload_store [dfp_pkg::STORE_DEPTH];
    frame_result_t   expected_results [$];
    int unsigned     errors;

    function new();
      phase      = dfp_pkg::PH_IDLE;
      held_type  = '0;
      fill_count = 0;
      errors     = 0;
    endfunction

    function void push_result(logic [7:0] pbyte, int unsigned idx, int unsigned len,
                              logic empty, logic fin);
      frame_result_t r;
      r.ftype = held_type;
      r.pbyte = pbyte;
      r.idx   = idx[5:0];
      r.len   = len[5:0];
      r.empty = empty;
      r.fin   = fin;
      expected_results.push_back(r);
    endfunction

    // Advance the parser state by one accepted byte.
    function void take_byte(logic [7:0] b);
      case (phase)
        dfp_pkg::PH_IDLE: begin
          if (b == dfp_pkg::CH_OPEN) phase = dfp_pkg::PH_TYPE;
        end
        dfp_pkg::PH_TYPE: begin
          held_type = b;
          phase     = dfp_pkg::PH_SEP;
        end
        dfp_pkg::PH_SEP: begin
          phase = (b == dfp_pkg::CH_SEP) ? dfp_pkg::PH_DATA : dfp_pkg::PH_IDLE;
        end
        default: begin
          if (b == dfp_pkg::CH_CLOSE) begin
            if (fill_count == 0) begin
              push_result(8'h00, 0, 0, 1'b1, 1'b1);
            end else begin
              for (int unsigned i = 0; i < fill_count && i < dfp_pkg::HW_CAP - 1; i++)
                push_result(payload_store[i], i, fill_count, 1'b0, (i + 1 == fill_count));
            end
            fill_count = 0;
            phase      = dfp_pkg::PH_IDLE;
          end else begin
            if (fill_count < dfp_pkg::STORE_DEPTH) payload_store[fill_count] = b;
            fill_count++;
            // overlong frame: dropped without any result
            if (fill_count >= dfp_pkg::FILL_LIMIT) begin
              fill_count = 0;
              phase      = dfp_pkg::PH_IDLE;
            end
          end
        end
      endcase
    endfunction

    function void check_result(logic [7:0] ftype, logic [7:0] pbyte, logic [5:0] idx,
                               logic [5:0] len, logic empty, logic fin);
      frame_result_t e;
      if (expected_results.size() == 0) begin
        $error("unexpected result: frame_type %0h payload_byte %0h byte_index %0d",
               ftype, pbyte, idx);
        errors++;
        return;
      end
      e = expected_results.pop_front();
      if (ftype !== e.ftype) begin
        $error("frame_type: expected %0h, got %0h", e.ftype, ftype);
        errors++;
      end
      if (pbyte !== e.pbyte) begin
        $error("payload_byte: expected %0h, got %0h", e.pbyte, pbyte);
        errors++;
      end
      if (idx !== e.idx) begin
        $error("byte_index: expected %0d, got %0d", e.idx, idx);
        errors++;
      end
      if (len !== e.len) begin
        $error("frame_length: expected %0d, got %0d", e.len, len);
        errors++;
      end
      if (empty !== e.empty) begin
        $error("empty_frame: expected %0b, got %0b", e.empty, empty);
        errors++;
      end
      if (fin !== e.fin) begin
        $error("last: expected %0b, got %0b", e.fin, fin);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction
  endclass

  logic       clk;
  logic       rst;
  logic       byte_valid;
  logic       byte_ready;
  logic [7:0] in_byte;
  logic       result_valid;
  logic       result_ready;
  logic [7:0] frame_type;
  logic [7:0] payload_byte;
  logic [5:0] byte_index;
  logic [5:0] frame_length;
  logic       empty_frame;
  logic       last;

  frame_scoreboard sb = new();
  int unsigned     send_idle_pct;
  int unsigned     stall_pct;
  int unsigned     bytes_sent;
  int unsigned     cycle_count;

  delimited_frame_parser_unit dut (
    .clk         (clk),
    .rst         (rst),
    .byte_valid  (byte_valid),
    .byte_ready  (byte_ready),
    .in_byte     (in_byte),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .frame_type  (frame_type),
    .payload_byte(payload_byte),
    .byte_index  (byte_index),
    .frame_length(frame_length),
    .empty_frame (empty_frame),
    .last        (last)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Result side: check accepted items, randomize ready for the next cycle.
  always @(posedge clk) begin
    if (!rst && result_valid && result_ready)
      sb.check_result(frame_type, payload_byte, byte_index, frame_length, empty_frame, last);
    result_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      byte_valid <= 1'b0;
      @(posedge clk);
    end
    byte_valid <= 1'b1;
    in_byte    <= b;
    @(posedge clk);
    while (!byte_ready) @(posedge clk);
    sb.take_byte(b);
    bytes_sent++;
  endtask

  task automatic drain_results();
    byte_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  function automatic logic [7:0] pick_type();
    case ($urandom_range(0, 9))
      0:       return dfp_pkg::CH_OPEN;
      1:       return dfp_pkg::CH_SEP;
      2:       return dfp_pkg::CH_CLOSE;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] pick_payload();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    case ($urandom_range(0, 19))
      0: b = dfp_pkg::CH_OPEN;
      1: b = dfp_pkg::CH_SEP;
      default: ;
    endcase
    // an early '$' is kept now and then; otherwise steer away so frames grow
    if (b == dfp_pkg::CH_CLOSE && $urandom_range(0, 9) != 0) b = ~b;
    return b;
  endfunction

  task automatic send_random_frame();
    int unsigned kind;
    int unsigned n;
    int unsigned sel;
    logic [7:0]  b;
    kind = $urandom_range(0, 99);
    if (kind < 10) begin
      // noise between frames
      n = $urandom_range(1, 3);
      repeat (n) begin
        b = 8'($urandom_range(0, 255));
        if (b == dfp_pkg::CH_OPEN) b = 8'h00;
        send_byte(b);
      end
    end else if (kind < 18) begin
      // separator missing
      send_byte(dfp_pkg::CH_OPEN);
      send_byte(pick_type());
      b = 8'($urandom_range(0, 255));
      if (b == dfp_pkg::CH_SEP) b = dfp_pkg::CH_CLOSE;
      send_byte(b);
    end else begin
      sel = $urandom_range(0, 99);
      if (sel < 6) begin
        case ($urandom_range(0, 3))
          0:       n = 62;
          1:       n = 63;
          2:       n = 64;
          default: n = 66;
        endcase
      end else if (sel < 20) begin
        n = $urandom_range(9, 30);
      end else begin
        n = $urandom_range(0, 8);
      end
      send_byte(dfp_pkg::CH_OPEN);
      send_byte(pick_type());
      send_byte(dfp_pkg::CH_SEP);
      repeat (n) send_byte(pick_payload());
      send_byte(dfp_pkg::CH_CLOSE);
    end
  endtask

  task automatic run_random_phase(input int unsigned idle_pct, input int unsigned stall,
                                  input int unsigned byte_goal);
    send_idle_pct = idle_pct;
    stall_pct     = stall;
    while (bytes_sent < byte_goal) send_random_frame();
    drain_results();
  endtask

  initial begin
    rst           <= 1'b1;
    byte_valid    <= 1'b0;
    in_byte       <= 8'h00;
    result_ready  <= 1'b0;
    send_idle_pct  = 0;
    stall_pct      = 0;
    bytes_sent     = 0;
    cycle_count    = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: stray bytes, empty frames, missing separator, markers as data
    send_idle_pct = 27;
    stall_pct     = 81;
    send_byte(8'h78);
    send_byte(dfp_pkg::CH_CLOSE);
    send_byte(dfp_pkg::CH_SEP);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(dfp_pkg::CH_OPEN);  send_byte(8'hFF);
    send_byte(dfp_pkg::CH_SEP);   send_byte(dfp_pkg::CH_CLOSE);
    send_byte(dfp_pkg::CH_OPEN);  send_byte(dfp_pkg::CH_OPEN);  send_byte(8'h5A);
    send_byte(dfp_pkg::CH_OPEN);  send_byte(dfp_pkg::CH_CLOSE); send_byte(dfp_pkg::CH_SEP);
    send_byte(8'h00);             send_byte(dfp_pkg::CH_OPEN);
    send_byte(dfp_pkg::CH_SEP);   send_byte(8'hFF);
    send_byte(dfp_pkg::CH_CLOSE);
    send_byte(dfp_pkg::CH_OPEN);  send_byte(dfp_pkg::CH_SEP);
    send_byte(dfp_pkg::CH_SEP);   send_byte(dfp_pkg::CH_CLOSE);
    drain_results();

    run_random_phase(27, 81, BYTE_TARGET / 3);
    run_random_phase(81, 27, 2 * BYTE_TARGET / 3);
    run_random_phase(0, 0, BYTE_TARGET);

    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/dfp_pkg.sv
rtl/dfp_store.sv
rtl/dfp_parse.sv
rtl/dfp_emit.sv
rtl/delimited_frame_parser_unit.sv
rtl/dfp_checker.sv
tb/tb_top.sv
